// ===== hw/rtl/msel_pkg.sv =====
// ----------------------------------------------------------------------------
// msel_pkg
// Shared types and constants for the median select core.
// ----------------------------------------------------------------------------
package msel_pkg;

    localparam int MSEL_MAX_ITEMS = 256;
    localparam int MSEL_DATA_W    = 32;

    typedef struct packed {
        logic [MSEL_DATA_W-1:0] sample_value;
        logic                   set_end;
    } msel_in_t;

    typedef struct packed {
        logic [MSEL_DATA_W-1:0] median_value;
        logic                   run_end;
        logic                   capacity_exceeded;
    } msel_out_t;

    typedef struct packed {
        logic load;
        logic shift;
    } msel_ctrl_t;

endpackage

// ===== hw/rtl/msel_cell.sv =====
// ----------------------------------------------------------------------------
// msel_cell
// One slot of the sorted chain: insert by compare against the broadcast
// value, or shift toward slot zero for readout.
// ----------------------------------------------------------------------------
module msel_cell
    import msel_pkg::*;
(
    input  logic                   clk,
    input  msel_ctrl_t             ctrl,
    input  logic [MSEL_DATA_W-1:0] sample,
    input  logic                   occupied,
    input  logic [MSEL_DATA_W-1:0] left_val,
    input  logic                   left_gt,
    input  logic [MSEL_DATA_W-1:0] right_val,
    output logic [MSEL_DATA_W-1:0] val,
    output logic                   gt
);

    logic [MSEL_DATA_W-1:0] val_reg;
    logic [MSEL_DATA_W-1:0] val_next;

    // unoccupied slots rank above any value
    assign gt  = ~occupied | (val_reg > sample);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load)
        begin
            if (left_gt)
            begin
                val_next = left_val;
            end
            else if (gt)
            begin
                val_next = sample;
            end
        end
        else if (ctrl.shift)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== hw/rtl/median_select_core.sv =====
// ----------------------------------------------------------------------------
// median_select_core
// Median of a set of unsigned values, kept sorted in a chain of cells.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  input   | start & !busy          | item   (sample_value, set_end)
//  result  | result_valid, 1 cycle  | result (median_value, run_end,
//          |                        |         capacity_exceeded)
//
// An item is inserted on accept; the chain compares all cells at once.
// After a final item with n values held, cell zero is read while the chain
// shifts; busy until it gives the median (odd n) or both middle values (even n).
// Results leave from an output register in the cycle after they are selected.
// Reset clears the count, the overflow flag and the sequencer; cells keep data.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module median_select_core
    import msel_pkg::*;
#(
    parameter int MAX_ITEMS = MSEL_MAX_ITEMS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  msel_in_t  item,
    output logic      result_valid,
    output msel_out_t result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_ITEMS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SEEK  = 2'd1;
    localparam logic [1:0] ST_EMIT2 = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic             odd_reg, odd_next;
    logic             result_valid_reg, result_valid_next;
    msel_out_t        result_reg, result_next;

    logic             accept;
    logic             full;
    logic [CNT_W-1:0] new_count;
    logic [CNT_W-1:0] lower_idx;
    msel_ctrl_t       ctrl;

    logic [MSEL_DATA_W-1:0] cell_val [MAX_ITEMS];
    logic                   cell_gt  [MAX_ITEMS];

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start & ~busy;
    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign new_count = full ? count_reg : count_reg + CNT_W'(1);
    assign lower_idx = (new_count - CNT_W'(1)) >> 1;

    assign ctrl.load  = accept & ~full;
    assign ctrl.shift = (state_reg == ST_SEEK);

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic [MSEL_DATA_W-1:0] left_val;
            logic                   left_gt;
            logic [MSEL_DATA_W-1:0] right_val;

            if (i == 0)
            begin : g_first
                assign left_val = '0;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_mid
                assign left_val = cell_val[i-1];
                assign left_gt  = cell_gt[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_inner
                assign right_val = cell_val[i+1];
            end

            msel_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .sample    (item.sample_value),
                .occupied  (count_reg > CNT_W'(i)),
                .left_val  (left_val),
                .left_gt   (left_gt),
                .right_val (right_val),
                .val       (cell_val[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        rem_next          = rem_reg;
        odd_next          = odd_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = new_count;
                    ovf_next   = ovf_reg | full;
                    if (item.set_end)
                    begin
                        rem_next   = lower_idx[IDX_W-1:0];
                        odd_next   = new_count[0];
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK:
            begin
                if (rem_reg == '0)
                begin
                    result_valid_next              = 1'b1;
                    result_next.median_value       = cell_val[0];
                    result_next.run_end            = odd_reg;
                    result_next.capacity_exceeded  = ovf_reg;
                    if (odd_reg)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT2;
                    end
                end
                else
                begin
                    rem_next = rem_reg - IDX_W'(1);
                end
            end
            ST_EMIT2:
            begin
                result_valid_next             = 1'b1;
                result_next.median_value      = cell_val[0];
                result_next.run_end           = 1'b1;
                result_next.capacity_exceeded = ovf_reg;
                state_next                    = ST_IDLE;
                count_next                    = '0;
                ovf_next                      = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            rem_reg          <= '0;
            odd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            rem_reg          <= rem_next;
            odd_reg          <= odd_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sim/msel_checker.sv =====
// ----------------------------------------------------------------------------
// msel_checker
// Watches the item and result channels of the median select core, keeps a
// sorted copy of every set it sees and compares each median result, field by
// field, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module msel_checker
    import msel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  msel_in_t  item,
    input  logic      result_valid,
    input  msel_out_t result,
    output int        fail_count,
    output int        pending,
    output int        sets_done,
    output int        spill_sets,
    output int        results_seen
);

    logic [MSEL_DATA_W-1:0] ranked[$];
    logic                   spilled;
    msel_out_t              median_q[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] msel_checker: %s", $time, msg);
        fail_count++;
    endtask

    // insertion into the ascending copy; a full store drops the value
    function automatic void rank_sample(input logic [MSEL_DATA_W-1:0] v);
        int pos;
        if (ranked.size() >= MSEL_MAX_ITEMS)
        begin
            spilled = 1'b1;
            return;
        end
        pos = ranked.size();
        while (pos > 0 && ranked[pos-1] > v)
            pos--;
        ranked.insert(pos, v);
    endfunction

    function automatic void take_sample(input msel_in_t smp);
        int        held;
        int        mid;
        msel_out_t lo;
        msel_out_t hi;
        rank_sample(smp.sample_value);
        if (!smp.set_end)
            return;
        held = ranked.size();
        mid  = held / 2;
        if (held % 2 == 1)
        begin
            hi = '{median_value: ranked[mid], run_end: 1'b1, capacity_exceeded: spilled};
            median_q.push_back(hi);
        end
        else
        begin
            lo = '{median_value: ranked[mid-1], run_end: 1'b0, capacity_exceeded: spilled};
            hi = '{median_value: ranked[mid], run_end: 1'b1, capacity_exceeded: spilled};
            median_q.push_back(lo);
            median_q.push_back(hi);
        end
        sets_done++;
        if (spilled)
            spill_sets++;
        ranked.delete();
        spilled = 1'b0;
    endfunction

    task automatic check_result(input msel_out_t got);
        msel_out_t want;
        results_seen++;
        if (median_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result median %h run_end %b ovf %b",
                                      got.median_value, got.run_end,
                                      got.capacity_exceeded));
            return;
        end
        want = median_q.pop_front();
        if (got.median_value !== want.median_value)
            report_mismatch($sformatf("median_value expected %h got %h",
                                      want.median_value, got.median_value));
        if (got.run_end !== want.run_end)
            report_mismatch($sformatf("run_end expected %b got %b",
                                      want.run_end, got.run_end));
        if (got.capacity_exceeded !== want.capacity_exceeded)
            report_mismatch($sformatf("capacity_exceeded expected %b got %b",
                                      want.capacity_exceeded, got.capacity_exceeded));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranked.delete();
            median_q.delete();
            spilled      = 1'b0;
            fail_count   = 0;
            sets_done    = 0;
            spill_sets   = 0;
            results_seen = 0;
        end
        else
        begin
            if (start && !busy)
                take_sample(item);
            if (result_valid)
                check_result(result);
        end
        pending = median_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sets of values into the median select core: a short directed run of
// extremes, equal values and both parities, then random sets with random
// sender gaps, including a set that exactly fills the store and one that
// overflows it. Checking is done by msel_checker.
// ----------------------------------------------------------------------------
module tb_top
    import msel_pkg::*;
();

    localparam int ITEM_TARGET = 850;
    localparam int QUIET_LIMIT = 2000;

    typedef enum int {VAL_WIDE, VAL_DUPS, VAL_EDGE, VAL_MIX} value_mix_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      start        = 1'b0;
    msel_in_t  item         = '0;
    logic      busy;
    logic      result_valid;
    msel_out_t result;

    int fail_count;
    int pending;
    int sets_done;
    int spill_sets;
    int results_seen;
    int items_sent  = 0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    median_select_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    msel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .sets_done    (sets_done),
        .spill_sets   (spill_sets),
        .results_seen (results_seen)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no item or result for %0d cycles", QUIET_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [MSEL_DATA_W-1:0] pick_value(input value_mix_t mix);
        case (mix)
            VAL_WIDE: return $urandom();
            VAL_DUPS: return $urandom_range(0, 7);
            VAL_EDGE:
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    3:       return 32'h7fff_ffff;
                    default: return 32'h0000_0001;
                endcase
            default: return pick_value(value_mix_t'($urandom_range(0, 2)));
        endcase
    endfunction

    task automatic send_sample(input logic [MSEL_DATA_W-1:0] v, input logic last);
        start <= 1'b1;
        item  <= '{sample_value: v, set_end: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic sender_gap(input bit steady);
        int g;
        g = steady ? 0 : $urandom_range(0, 5);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // hold off until every pending median has come out
    task automatic wait_for_medians();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_list(input logic [MSEL_DATA_W-1:0] vals[$], input bit steady);
        for (int i = 0; i < vals.size(); i++)
        begin
            send_sample(vals[i], i == vals.size() - 1);
            sender_gap(steady);
        end
    endtask

    task automatic send_set(input int len, input value_mix_t mix, input bit steady);
        for (int i = 0; i < len; i++)
        begin
            send_sample(pick_value(mix), i == len - 1);
            sender_gap(steady);
        end
    endtask

    initial
    begin
        logic [MSEL_DATA_W-1:0] vals[$];
        int                     set_no;
        int                     len;
        bit                     steady;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single values, two-value extremes, equal values, both orders
        vals = {32'h0000_0000};
        send_list(vals, 1'b1);
        vals = {32'hffff_ffff};
        send_list(vals, 1'b0);
        vals = {32'hffff_ffff, 32'h0000_0000};
        send_list(vals, 1'b1);
        vals = {32'h5, 32'h5, 32'h5};
        send_list(vals, 1'b0);
        vals = {32'hffff_ffff, 32'haaaa_aaaa, 32'h8000_0000, 32'h7fff_ffff,
                32'h5555_5555, 32'h0000_0000};
        send_list(vals, 1'b1);
        vals = {32'h0, 32'h1, 32'h2, 32'h3, 32'h4};
        send_list(vals, 1'b0);
        vals = {32'h3, 32'h3, 32'h3, 32'h1};
        send_list(vals, 1'b1);
        wait_for_medians();

        // random sets; one fills the store exactly, one overruns it
        set_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                wait_for_medians();
            if (set_no == 6)
                len = MSEL_MAX_ITEMS;
            else if (set_no == 20)
                len = MSEL_MAX_ITEMS + 4;
            else
                len = $urandom_range(1, 12);
            send_set(len, value_mix_t'($urandom_range(0, 3)), steady);
            set_no++;
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d items in %0d sets; %0d median results checked.",
                 items_sent, sets_done, results_seen);
        $display("Sets that overran the %0d-entry store: %0d.", MSEL_MAX_ITEMS, spill_sets);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/msel_pkg.sv
hw/rtl/msel_cell.sv
hw/rtl/median_select_core.sv
sim/msel_checker.sv
sim/tb_top.sv
